>>> rtl/ufbd_pkg.sv
// Package: shared types, widths and the prescaler code table for the baud divisor block.
package ufbd_pkg;

  localparam int DIVD_W = 48;
  localparam int DIVS_W = 32;

  typedef struct packed {
    logic [23:0] baud_rate;
    logic [31:0] source_clock_hz;
  } in_t;

  typedef struct packed {
    logic [2:0]  prescale_code;
    logic [15:0] increment_value;
    logic [15:0] modulus_value;
    logic        accepted;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
    logic [DIVS_W-1:0] remainder;
  } div_rsp_t;

  localparam logic [2:0] PRE_CODE_DIV1 = 3'h5;
  localparam logic [2:0] PRE_CODE_DIV2 = 3'h4;
  localparam logic [2:0] PRE_CODE_DIV3 = 3'h3;
  localparam logic [2:0] PRE_CODE_DIV4 = 3'h2;
  localparam logic [2:0] PRE_CODE_DIV5 = 3'h1;
  localparam logic [2:0] PRE_CODE_DIV6 = 3'h0;
  localparam logic [2:0] PRE_CODE_DIV7 = 3'h6;

  function automatic logic [2:0] prescale_to_code(input logic [2:0] d);
    logic [2:0] c;
    case (d)
      3'd1: c = PRE_CODE_DIV1;
      3'd2: c = PRE_CODE_DIV2;
      3'd3: c = PRE_CODE_DIV3;
      3'd4: c = PRE_CODE_DIV4;
      3'd5: c = PRE_CODE_DIV5;
      3'd6: c = PRE_CODE_DIV6;
      3'd7: c = PRE_CODE_DIV7;
      default: c = PRE_CODE_DIV1;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/ufbd_divider.sv
// Module: restoring serial divider, one quotient bit per cycle.
module ufbd_divider (
  input  logic               clk,
  input  logic               rst,
  input  ufbd_pkg::div_req_t req,
  output ufbd_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(ufbd_pkg::DIVD_W + 1);

  logic [ufbd_pkg::DIVD_W-1:0] quo;
  logic [ufbd_pkg::DIVS_W-1:0] rem;
  logic [ufbd_pkg::DIVS_W-1:0] dvs;
  logic [CNT_W-1:0]            cnt;
  logic                        running;
  logic                        done;
  logic [ufbd_pkg::DIVS_W:0]   rem_sh;
  logic                        fits;

  assign rem_sh = {rem, quo[ufbd_pkg::DIVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(ufbd_pkg::DIVD_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (running) begin
      quo <= {quo[ufbd_pkg::DIVD_W-2:0], fits};
      rem <= fits ? ufbd_pkg::DIVS_W'(rem_sh - {1'b0, dvs})
                  : ufbd_pkg::DIVS_W'(rem_sh);
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

>>> rtl/uart_fractional_baud_divisor.sv
// Top level: sequencer that works out fractional UART divider settings on one shared divider.
// Each request runs two Euclid passes on the divider plus up to twelve further divisions and
// one multiply; a zero baud rate or clock is rejected without using the divider.
// Throughput: one request at a time; busy stays high until the result strobe.
// Reset: synchronous active-high rst returns the sequencer to idle and drops done.
module uart_fractional_baud_divisor #(
  parameter int FIELD_MAX = 65535
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ufbd_pkg::in_t  request,
  output logic           done,
  output ufbd_pkg::out_t result
);

  localparam logic [31:0] FMAX  = 32'(FIELD_MAX);
  localparam logic [31:0] FMAX7 = 32'(7 * FIELD_MAX);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EUC  = 6'b000010,
    S_DIV  = 6'b000100,
    S_WAIT = 6'b001000,
    S_MUL  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    OP_EUC, OP_NUM, OP_DEN, OP_M, OP_N, OP_SN, OP_SD, OP_PRE,
    OP_TN, OP_TD, OP_EST, OP_B100, OP_MOD
  } op_t;

  state_t state;
  op_t    op;
  logic   second;
  logic   reject;

  logic [23:0] baud;
  logic [31:0] clkhz;
  logic [31:0] a, b, g;
  logic [31:0] num, den, m, k;
  logic [2:0]  pre;
  logic [31:0] tn, td;
  logic [47:0] prod, est;
  logic [23:0] b100;
  logic [15:0] modq;

  ufbd_pkg::div_req_t dreq;
  ufbd_pkg::div_rsp_t drsp;

  ufbd_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Pick divider operands for the current step.
  always_comb begin
    dreq.start    = (state == S_DIV);
    dreq.dividend = '0;
    dreq.divisor  = 32'd1;
    case (op)
      OP_EUC:  begin dreq.dividend = 48'(a);                dreq.divisor = b;     end
      OP_NUM:  begin dreq.dividend = 48'(clkhz);            dreq.divisor = g;     end
      OP_DEN:  begin dreq.dividend = 48'({baud, 4'b0000});  dreq.divisor = g;     end
      OP_M:    begin dreq.dividend = 48'(num - 32'd1);      dreq.divisor = FMAX7; end
      OP_N:    begin dreq.dividend = 48'(den - 32'd1);      dreq.divisor = FMAX;  end
      OP_SN:   begin dreq.dividend = 48'(num);              dreq.divisor = k;     end
      OP_SD:   begin dreq.dividend = 48'(den);              dreq.divisor = k;     end
      OP_PRE:  begin dreq.dividend = 48'(num - 32'd1);      dreq.divisor = FMAX;  end
      OP_TN:   begin dreq.dividend = 48'(clkhz);            dreq.divisor = g;     end
      OP_TD:   begin dreq.dividend = 48'({num[27:0], 4'b0}); dreq.divisor = g;    end
      OP_EST:  begin dreq.dividend = prod;                  dreq.divisor = td;    end
      OP_B100: begin dreq.dividend = 48'(baud);             dreq.divisor = 32'd100; end
      OP_MOD:  begin
        dreq.dividend = 48'(num);
        dreq.divisor  = (pre == 3'd0) ? 32'd1 : 32'(pre);
      end
      default: begin dreq.dividend = '0;                    dreq.divisor = 32'd1; end
    endcase
  end

  logic [47:0] diff;
  logic [19:0] bound;
  assign diff  = (est >= 48'(baud)) ? est - 48'(baud) : 48'(baud) - est;
  assign bound = 20'(b100) * 20'd3;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_EUC;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EUC;
            if (request.baud_rate == '0 || request.source_clock_hz == '0) begin
              state <= S_FIN;
            end
          end
        end
        // Run Euclid: stop when the remainder is zero, else take one more modulo.
        S_EUC: begin
          state <= S_DIV;
          if (b == '0) begin
            op <= second ? OP_TN : OP_NUM;
          end else begin
            op <= OP_EUC;
          end
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: begin
          if (drsp.done) begin
            state <= S_DIV;
            case (op)
              OP_EUC:  state <= S_EUC;
              OP_NUM:  op <= OP_DEN;
              OP_DEN:  op <= OP_M;
              OP_M:    op <= OP_N;
              OP_N:    op <= OP_SN;
              OP_SN:   op <= OP_SD;
              OP_SD:   op <= OP_PRE;
              OP_PRE:  state <= S_EUC;
              OP_TN:   op <= OP_TD;
              OP_TD:   state <= S_MUL;
              OP_EST:  op <= OP_B100;
              OP_B100: op <= OP_MOD;
              OP_MOD:  state <= S_FIN;
              default: state <= S_FIN;
            endcase
            // Skip scaling when both terms already fit.
            if (op == OP_DEN && !(num > FMAX7 || 32'(drsp.quotient) > FMAX)) begin
              op <= OP_PRE;
            end
          end
        end
        S_MUL: begin
          state <= S_DIV;
          op    <= OP_EST;
        end
        S_FIN: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      baud   <= request.baud_rate;
      clkhz  <= request.source_clock_hz;
      a      <= request.source_clock_hz;
      b      <= 32'({request.baud_rate, 4'b0000});
      second <= 1'b0;
      reject <= (request.baud_rate == '0 || request.source_clock_hz == '0);
    end
    if (state == S_EUC && b == '0) begin
      g <= a;
    end
    if (state == S_MUL) begin
      prod <= 48'(tn) * 48'(den[15:0]);
    end
    if (state == S_WAIT && drsp.done) begin
      case (op)
        OP_EUC: begin
          a <= b;
          b <= drsp.remainder;
        end
        OP_NUM:  num <= 32'(drsp.quotient);
        OP_DEN:  den <= 32'(drsp.quotient);
        OP_M:    m   <= 32'(drsp.quotient) + 32'd1;
        OP_N:    k   <= (m > 32'(drsp.quotient) + 32'd1) ? m : 32'(drsp.quotient) + 32'd1;
        OP_SN:   num <= (drsp.quotient == '0) ? 32'd1 : 32'(drsp.quotient);
        OP_SD:   den <= (drsp.quotient == '0) ? 32'd1 : 32'(drsp.quotient);
        OP_PRE: begin
          pre    <= 3'(drsp.quotient) + 3'd1;
          a      <= clkhz;
          b      <= {num[27:0], 4'b0000};
          second <= 1'b1;
        end
        OP_TN:   tn   <= 32'(drsp.quotient);
        OP_TD:   td   <= 32'(drsp.quotient);
        OP_EST:  est  <= drsp.quotient;
        OP_B100: b100 <= 24'(drsp.quotient);
        OP_MOD:  modq <= 16'(drsp.quotient);
        default: ;
      endcase
    end
  end

  // Hold the result; zero fields when the request is rejected or the estimate misses the tolerance.
  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      if (!reject && 48'(bound) > diff) begin
        result.prescale_code   <= ufbd_pkg::prescale_to_code(pre);
        result.increment_value <= 16'(den - 32'd1);
        result.modulus_value   <= modq - 16'd1;
        result.accepted        <= 1'b1;
      end else begin
        result <= '0;
      end
    end
  end

endmodule

>>> tb/tb_uart_fractional_baud_divisor.sv
// Testbench for the fractional UART baud divisor calculator: directed and random requests.
module tb_uart_fractional_baud_divisor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FMAX = 65535;
  // The idle limit sits well above the longest request.
  localparam int STALL_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 6000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  ufbd_pkg::in_t request;
  logic done;
  ufbd_pkg::out_t result;

  // Expected settings, oldest first.
  ufbd_pkg::out_t settings_q[$];
  int errors;
  int idle_cycles;
  int idle_pct;
  bit accepted_now;

  uart_fractional_baud_divisor #(.FIELD_MAX(FMAX)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [63:0] euclid(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] g;
    logic [63:0] t;
    g = 64'd1;
    while (b != 0) begin
      g = b;
      t = a % b;
      b = t;
      a = g;
    end
    return g;
  endfunction

  function automatic logic [2:0] code_of(input logic [63:0] d);
    case (d)
      64'd1: return ufbd_pkg::PRE_CODE_DIV1;
      64'd2: return ufbd_pkg::PRE_CODE_DIV2;
      64'd3: return ufbd_pkg::PRE_CODE_DIV3;
      64'd4: return ufbd_pkg::PRE_CODE_DIV4;
      64'd5: return ufbd_pkg::PRE_CODE_DIV5;
      64'd6: return ufbd_pkg::PRE_CODE_DIV6;
      64'd7: return ufbd_pkg::PRE_CODE_DIV7;
      default: return ufbd_pkg::PRE_CODE_DIV1;
    endcase
  endfunction

  // Work out the divider settings the block should report for one request.
  function automatic ufbd_pkg::out_t divisor_settings(input ufbd_pkg::in_t req);
    ufbd_pkg::out_t o;
    logic [63:0] baud, clkhz, g, num, den, m, n, k, pre, tn, td, est, diff;
    o = '0;
    baud = 64'(req.baud_rate);
    clkhz = 64'(req.source_clock_hz);
    if (baud == 0 || clkhz == 0) return o;
    g = euclid(clkhz, baud << 4);
    num = clkhz / g;
    den = (baud << 4) / g;
    // Scale both terms down by one common factor when either overflows its field.
    if (num > FMAX * 7 || den > FMAX) begin
      m = (num - 1) / (FMAX * 7) + 1;
      n = (den - 1) / FMAX + 1;
      k = (m > n) ? m : n;
      num = num / k;
      den = den / k;
      if (num == 0) num = 1;
      if (den == 0) den = 1;
    end
    pre = (num - 1) / FMAX + 1;
    g = euclid(clkhz, num << 4);
    tn = clkhz / g;
    td = (num << 4) / g;
    if (td == 0) return o;
    est = (tn * den) / td;
    diff = (est >= baud) ? est - baud : baud - est;
    if (diff < (baud / 100) * 3) begin
      o.prescale_code = code_of(pre);
      o.increment_value = 16'(den - 1);
      o.modulus_value = 16'(num / ((pre >= 1 && pre <= 7) ? pre : 64'd1) - 1);
      o.accepted = 1'b1;
    end
    return o;
  endfunction

  // Wait out sender idling, raise start and hold it until the block takes the request.
  task automatic send_request(input logic [23:0] baud, input logic [31:0] hz);
    ufbd_pkg::in_t req;
    bit taken;
    req.baud_rate = baud;
    req.source_clock_hz = hz;
    taken = 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    request <= req;
    // busy only moves on rising edges, so its mid-cycle value decides the next edge.
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    settings_q.push_back(divisor_settings(req));
  endtask

  task automatic test_field_extremes();
    send_request(24'd0, 32'd50_000_000);
    send_request(24'hFFFFFF, 32'hFFFFFFFF);
    send_request(24'd1, 32'd1);
    send_request(24'd1, 32'hFFFFFFFF);
    send_request(24'hFFFFFF, 32'd1);
    send_request(24'd99, 32'd48_000_000);
    send_request(24'd100, 32'd48_000_000);
    send_request(24'd115200, 32'd0);
    send_request(24'h000000, 32'h00000000);
  endtask

  task automatic test_standard_rates();
    send_request(24'd9600, 32'd1_843_200);
    send_request(24'd115200, 32'd48_000_000);
    send_request(24'd115200, 32'd100_000_000);
    send_request(24'd921600, 32'd24_000_000);
    send_request(24'd3_000_000, 32'd48_000_000);
    send_request(24'd300, 32'd200_000_000);
    send_request(24'd57600, 32'd14_745_600);
  endtask

  // Step the clock with d from 1 to 7 times the field limit against a tiny baud rate.
  task automatic test_prescale_range();
    for (int d = 1; d <= 7; d++)
      send_request(24'd101, 32'((d * FMAX - 100) * 16 * 101 / 100));
  endtask

  task automatic test_random_requests(input int count);
    logic [23:0] b;
    logic [31:0] h;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: b = 24'($urandom);
        1: b = 24'($urandom_range(4_000_000, 100));
        2: b = 24'($urandom_range(200, 0));
        default: b = 24'($urandom_range(1_000_000, 1200));
      endcase
      h = ($urandom_range(1)) ? $urandom : $urandom_range(200_000_000, 1_000_000);
      send_request(b, h);
    end
  endtask

  // Compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (settings_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, result);
        errors++;
      end else begin
        ufbd_pkg::out_t exp_s;
        exp_s = settings_q.pop_front();
        if (result.prescale_code !== exp_s.prescale_code) begin
          $display("%0t: prescale_code expected %0d actual %0d", $time,
                   exp_s.prescale_code, result.prescale_code);
          errors++;
        end
        if (result.increment_value !== exp_s.increment_value) begin
          $display("%0t: increment_value expected %0d actual %0d", $time,
                   exp_s.increment_value, result.increment_value);
          errors++;
        end
        if (result.modulus_value !== exp_s.modulus_value) begin
          $display("%0t: modulus_value expected %0d actual %0d", $time,
                   exp_s.modulus_value, result.modulus_value);
          errors++;
        end
        if (result.accepted !== exp_s.accepted) begin
          $display("%0t: accepted expected %0d actual %0d", $time,
                   exp_s.accepted, result.accepted);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no request taken and no result strobed.
  always @(posedge clk) begin
    accepted_now = (start && !busy) || done;
    if (rst || accepted_now) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_uart_fractional_baud_divisor: FAIL");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sweep idling phases: none, mostly idle, light idling, then none again.
    test_field_extremes();
    test_standard_rates();
    test_prescale_range();
    test_random_requests(30);
    idle_pct = 82;
    test_random_requests(30);
    idle_pct = 14;
    test_random_requests(30);
    idle_pct = 0;
    test_random_requests(27);
    start <= 1'b0;

    while (settings_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && settings_q.size() == 0) begin
      $display("tb_uart_fractional_baud_divisor: PASS");
    end else begin
      $display("tb_uart_fractional_baud_divisor: FAIL");
    end
    $finish;
  end

endmodule
